// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Request and status codes, field widths, and the command that the
// controller broadcasts to every cell of the key chain.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int KEY_W    = 16;
   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;

   // request types
   localparam logic [TYPE_W-1:0] REQ_INSERT   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DELETE   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DUMP     = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd6;
   localparam logic [STATUS_W-1:0] STAT_ENTRY     = 3'd7;

   // cell operations
   typedef logic [2:0] cell_op_type;
   localparam cell_op_type CELL_HOLD    = 3'd0;
   localparam cell_op_type CELL_COMPARE = 3'd1;
   localparam cell_op_type CELL_INSERT  = 3'd2;
   localparam cell_op_type CELL_DELETE  = 3'd3;
   localparam cell_op_type CELL_ROTATE  = 3'd4;

   typedef struct packed {
      cell_op_type      op;
      logic [KEY_W-1:0] key;
   } cell_cmd_type;

endpackage

// ----- hdl/skt_req_if.sv -----
// ----------------------------------------------------------------------------
// skt_req_if: request channel of the sorted key table
// Valid/ready channel carrying an operation code and a key.
// ----------------------------------------------------------------------------
interface skt_req_if import skt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [KEY_W-1:0]  key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

// ----- hdl/skt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// skt_rsp_if: result channel of the sorted key table
// Valid/ready channel carrying status, key, key count and a last marker.
// ----------------------------------------------------------------------------
interface skt_rsp_if import skt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    entry_key;
   logic [COUNT_W-1:0]  entry_count;
   logic                last;

   modport source (output valid, output status, output entry_key,
                   output entry_count, output last, input ready);
   modport sink   (input valid, input status, input entry_key,
                   input entry_count, input last, output ready);
endinterface

// ----- hdl/sorted_key_table_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_unit: ordered table of unique nonzero keys
// A chain of DEPTH cells keeps the keys in ascending order; insert and
// delete shift the chain in one step, dump rotates it out one key a beat.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  req_bus   in   valid / ready   req_type[1:0], key[15:0]
//  rsp_bus   out  valid / ready   status[2:0], entry_key[15:0],
//                                 entry_count[5:0], last
//
//  Insert and delete: a request is taken only while idle; every cell's
//  compare flags are registered, then the shift is committed and the
//  result register loaded once free. Dump: after the compare, one key per
//  cycle while results are taken, as the chain rotates under the result register.
//  Reset clears the key count, the control state and the result valid;
//  the cell keys are left as they are. A stalled result holds the chain.
//
module sorted_key_table_unit import skt_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   skt_req_if.sink     req_bus,
   skt_rsp_if.source   rsp_bus
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       dump_idx_ff, dump_idx_in;
   logic [TYPE_W-1:0]   req_type_ff, req_type_in;
   logic [KEY_W-1:0]    req_key_ff, req_key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                load_rsp;
   logic                rsp_free;
   logic                any_eq;
   logic [CW+COUNT_W-1:0] count_wide;
   cell_cmd_type        cmd;

   logic [KEY_W-1:0]    cell_key       [DEPTH];
   logic [KEY_W-1:0]    cell_left_key  [DEPTH];
   logic [KEY_W-1:0]    cell_right_key [DEPTH];
   logic [DEPTH-1:0]    cell_lt;
   logic [DEPTH-1:0]    cell_left_lt;
   logic [DEPTH-1:0]    cell_eq;

   // build the chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_left_key[i] = cell_key[i];
         assign cell_left_lt[i]  = 1'b1;
      end else begin : g_body
         assign cell_left_key[i] = cell_key[i-1];
         assign cell_left_lt[i]  = cell_lt[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign cell_right_key[i] = cell_key[i];
      end else begin : g_mid
         assign cell_right_key[i] = cell_key[i+1];
      end

      skt_cell #(
         .IDX   (i),
         .CNT_W (CW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .key_count (count_ff),
         .left_key  (cell_left_key[i]),
         .left_lt   (cell_left_lt[i]),
         .right_key (cell_right_key[i]),
         .wrap_key  (cell_key[0]),
         .key_out   (cell_key[i]),
         .lt_out    (cell_lt[i]),
         .eq_out    (cell_eq[i])
      );
   end

   assign any_eq   = |cell_eq;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == S_IDLE);

   // report the count modulo the field width
   assign count_wide = {{COUNT_W{1'b0}}, count_in};

   // sequence compare, commit and dump
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      req_type_in   = req_type_ff;
      req_key_in    = req_key_ff;
      cmd.op        = CELL_HOLD;
      cmd.key       = req_key_ff;
      load_rsp      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = req_key_ff;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid && (req_bus.req_type != REQ_RESERVED)) begin
               req_type_in = req_bus.req_type;
               req_key_in  = req_bus.key;
               cmd.op      = CELL_COMPARE;
               cmd.key     = req_bus.key;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
               priority if (req_type_ff == REQ_INSERT) begin
                  priority if (req_key_ff == '0) begin
                     rsp_status_in = STAT_INVALID;
                  end else if (any_eq) begin
                     rsp_status_in = STAT_DUPLICATE;
                  end else if (count_ff == CW'(DEPTH)) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     rsp_status_in = STAT_INSERTED;
                     cmd.op        = CELL_INSERT;
                     count_in      = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_status_in = STAT_EMPTY;
               end else if (req_type_ff == REQ_DELETE) begin
                  priority if (req_key_ff == '0) begin
                     rsp_status_in = STAT_INVALID;
                  end else if (!any_eq) begin
                     rsp_status_in = STAT_NOT_FOUND;
                  end else begin
                     rsp_status_in = STAT_DELETED;
                     cmd.op        = CELL_DELETE;
                     count_in      = count_ff - CW'(1);
                  end
               end else begin
                  // nonempty dump: no result yet, start rotating
                  load_rsp    = 1'b0;
                  dump_idx_in = '0;
                  state_in    = S_DUMP;
               end
            end
         end
         S_DUMP: begin
            if (rsp_free) begin
               load_rsp      = 1'b1;
               rsp_status_in = STAT_ENTRY;
               rsp_key_in    = cell_key[0];
               rsp_last_in   = (dump_idx_ff == count_ff - CW'(1));
               cmd.op        = CELL_ROTATE;
               if (rsp_last_in) begin
                  dump_idx_in = '0;
                  state_in    = S_IDLE;
               end else begin
                  dump_idx_in = dump_idx_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_count_in = count_wide[COUNT_W-1:0];

   // hold the result beat until taken
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      req_key_ff  <= req_key_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.entry_key   = rsp_key_ff;
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("key count exceeds table depth");

   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (count_ff != '0))
      else $error("dump running on an empty table");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (rsp_status_in == STAT_INSERTED)) |=>
      (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not advance the key count");

   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (rsp_status_in == STAT_ENTRY) && rsp_last_in) |=>
      (state_ff == S_IDLE))
      else $error("final dump beat did not return to idle");
`endif

endmodule

// ----- hdl/skt_cell.sv -----
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key chain
// Holds one key, compares it against the broadcast key, and on insert,
// delete and dump rotation loads a neighbor's, the broadcast or the head key.
// ----------------------------------------------------------------------------
module skt_cell import skt_pkg::*; #(
   parameter int IDX   = 0,
   parameter int CNT_W = 6
) (
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [CNT_W-1:0] key_count,
   input  logic [KEY_W-1:0] left_key,
   input  logic             left_lt,
   input  logic [KEY_W-1:0] right_key,
   input  logic [KEY_W-1:0] wrap_key,
   output logic [KEY_W-1:0] key_out,
   output logic             lt_out,
   output logic             eq_out
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             lt_ff, lt_in;
   logic             eq_ff, eq_in;
   logic             occupied;
   logic             tail;

   // slot position relative to the fill count
   assign occupied = key_count > CNT_W'(IDX);
   assign tail     = key_count == CNT_W'(IDX + 1);

   // pick next key and compare flags
   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_COMPARE: begin
            lt_in = occupied && (key_ff < cmd.key);
            eq_in = occupied && (key_ff == cmd.key);
         end
         CELL_INSERT: begin
            if (!lt_ff) begin
               key_in = left_lt ? cmd.key : left_key;
            end
         end
         CELL_DELETE: begin
            if (!lt_ff) begin
               key_in = right_key;
            end
         end
         CELL_ROTATE: begin
            key_in = tail ? wrap_key : right_key;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule
